// ----- rtl/core/cda_pkg.sv -----
// ----------------------------------------------------------------------------
// cda_pkg
// Shared types, constants and calendar helpers for the date-time advance core.
// ----------------------------------------------------------------------------
package cda_pkg;

  typedef struct packed {
    logic [13:0] start_year;
    logic [3:0]  start_month;
    logic [4:0]  start_day;
    logic [4:0]  start_hour;
    logic [5:0]  start_minute;
    logic [5:0]  start_second;
    logic [31:0] received_ms;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [13:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
    logic        date_valid;
  } rsp_t;

  // datapath commands
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_LEAP_Q,
    OP_LEAP_F,
    OP_CHECK,
    OP_DIV_MS,
    OP_SUM,
    OP_DAY_Q,
    OP_DAY_R,
    OP_HOUR_Q,
    OP_HOUR_R,
    OP_MIN_Q,
    OP_MIN_R,
    OP_STEP,
    OP_EMIT
  } op_t;

  typedef struct packed {
    logic ok;
    logic days_zero;
    logic year_roll;
  } sts_t;

  localparam logic [13:0] YEAR_MIN   = 14'd1970;
  localparam logic [3:0]  MONTH_MIN  = 4'd1;
  localparam logic [3:0]  MONTH_MAX  = 4'd12;
  localparam logic [3:0]  MONTH_FEB  = 4'd2;
  localparam logic [4:0]  DAY_MIN    = 5'd1;
  localparam logic [4:0]  HOUR_MAX   = 5'd23;
  localparam logic [5:0]  MINSEC_MAX = 6'd59;

  localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
  localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SEC_PER_MIN  = 6'd60;
  localparam logic [6:0]  YEARS_CENT   = 7'd100;

  // Reciprocals, exact over the operand ranges used:
  //   x / 1000          = (x * RECIP_MS)   >> 38, x < 2^32
  //   (x >> 7) / 675    = (.. * RECIP_DAY) >> 26, gives x / 86400
  //   (x >> 4) / 225    = (.. * RECIP_HOUR)>> 21, gives x / 3600
  //   (x >> 2) / 15     = (.. * RECIP_MIN) >> 14, gives x / 60
  //   (y >> 2) / 25     = (.. * RECIP_CENT)>> 17, gives y / 100
  localparam logic [28:0] RECIP_MS   = 29'd274877907;
  localparam logic [16:0] RECIP_DAY  = 17'd99421;
  localparam logic [13:0] RECIP_HOUR = 14'd9321;
  localparam logic [10:0] RECIP_MIN  = 11'd1093;
  localparam logic [12:0] RECIP_CENT = 13'd5243;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [3:0] idx;
    logic [4:0] len;
    idx = month - MONTH_MIN;
    if (month == MONTH_FEB) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (month < MONTH_MIN || month > MONTH_MAX) begin
      len = 5'd31;
    end else begin
      len = MONTH_LEN[idx];
    end
    return len;
  endfunction

endpackage

// ----- rtl/core/cda_datapath.sv -----
// ----------------------------------------------------------------------------
// cda_datapath
// Working registers, reciprocal dividers, validation and day stepper.
// ----------------------------------------------------------------------------
module cda_datapath (
  input  logic          clk,
  input  logic          rst,
  input  cda_pkg::op_t  op,
  input  cda_pkg::req_t req,
  output cda_pkg::sts_t sts,
  output cda_pkg::rsp_t rsp
);

  logic [13:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [31:0] delta;
  logic [7:0]  cent;
  logic        leap;
  logic        ok;
  logic [22:0] secs;
  logic [22:0] total;
  logic [5:0]  days;
  logic [16:0] rem_day;
  logic [11:0] rem_hour;

  logic [60:0] prod_ms;
  logic [24:0] prod_cent;
  logic [32:0] prod_day;
  logic [26:0] prod_hour;
  logic [20:0] prod_min;
  logic [14:0] cent_back;
  logic        div100;
  logic [4:0]  mdays;
  logic        day_end;
  logic        valid_now;
  logic [22:0] total_sum;

  assign prod_ms   = 61'(delta) * 61'(cda_pkg::RECIP_MS);
  assign prod_cent = 25'(year[13:2]) * 25'(cda_pkg::RECIP_CENT);
  assign prod_day  = 33'(total[22:7]) * 33'(cda_pkg::RECIP_DAY);
  assign prod_hour = 27'(rem_day[16:4]) * 27'(cda_pkg::RECIP_HOUR);
  assign prod_min  = 21'(rem_hour[11:2]) * 21'(cda_pkg::RECIP_MIN);

  assign cent_back = 15'(cent) * 15'(cda_pkg::YEARS_CENT);
  assign div100    = cent_back == {1'b0, year};

  assign mdays   = cda_pkg::month_days(month, leap);
  assign day_end = ({1'b0, day} + 6'd1) > {1'b0, mdays};

  assign valid_now = year >= cda_pkg::YEAR_MIN &&
                     month >= cda_pkg::MONTH_MIN && month <= cda_pkg::MONTH_MAX &&
                     day >= cda_pkg::DAY_MIN && day <= mdays &&
                     hour <= cda_pkg::HOUR_MAX &&
                     minute <= cda_pkg::MINSEC_MAX && second <= cda_pkg::MINSEC_MAX;

  // seconds since midnight of the start day plus elapsed seconds
  assign total_sum = secs + 23'(second) +
                     23'(minute) * 23'(cda_pkg::SEC_PER_MIN) +
                     23'(hour) * 23'(cda_pkg::SEC_PER_HOUR);

  assign sts.ok        = ok;
  assign sts.days_zero = days == 6'd0;
  assign sts.year_roll = day_end && month == cda_pkg::MONTH_MAX;

  always_ff @(posedge clk) begin
    unique case (op)
      cda_pkg::OP_LOAD: begin
        year   <= req.start_year;
        month  <= req.start_month;
        day    <= req.start_day;
        hour   <= req.start_hour;
        minute <= req.start_minute;
        second <= req.start_second;
        delta  <= req.now_ms - req.received_ms;
        days   <= 6'd0;
      end
      cda_pkg::OP_LEAP_Q: cent <= prod_cent[24:17];
      cda_pkg::OP_LEAP_F: begin
        leap <= (year[1:0] == 2'd0 && !div100) || (div100 && cent[1:0] == 2'd0);
      end
      cda_pkg::OP_CHECK:  ok <= valid_now;
      cda_pkg::OP_DIV_MS: secs <= prod_ms[60:38];
      cda_pkg::OP_SUM:    total <= total_sum;
      cda_pkg::OP_DAY_Q:  days <= prod_day[31:26];
      cda_pkg::OP_DAY_R: begin
        rem_day <= 17'(total - 23'(days) * 23'(cda_pkg::SEC_PER_DAY));
      end
      cda_pkg::OP_HOUR_Q: hour <= prod_hour[25:21];
      cda_pkg::OP_HOUR_R: begin
        rem_hour <= 12'(rem_day - 17'(hour) * 17'(cda_pkg::SEC_PER_HOUR));
      end
      cda_pkg::OP_MIN_Q:  minute <= prod_min[19:14];
      cda_pkg::OP_MIN_R: begin
        second <= 6'(rem_hour - 12'(minute) * 12'(cda_pkg::SEC_PER_MIN));
      end
      cda_pkg::OP_STEP: begin
        days <= days - 6'd1;
        if (day_end) begin
          day <= cda_pkg::DAY_MIN;
          if (month == cda_pkg::MONTH_MAX) begin
            month <= cda_pkg::MONTH_MIN;
            year  <= year + 14'd1;
          end else begin
            month <= month + 4'd1;
          end
        end else begin
          day <= day + 5'd1;
        end
      end
      cda_pkg::OP_EMIT: begin
        rsp.out_year   <= year;
        rsp.out_month  <= month;
        rsp.out_day    <= day;
        rsp.out_hour   <= hour;
        rsp.out_minute <= minute;
        rsp.out_second <= second;
        rsp.date_valid <= ok;
      end
      default: ;
    endcase
  end

  a_step_in_month: assert property (@(posedge clk) disable iff (rst)
    op == cda_pkg::OP_STEP |-> day >= cda_pkg::DAY_MIN && day <= mdays && days != 6'd0)
    else $error("day step outside the month or with no days left");

  a_day_split: assert property (@(posedge clk) disable iff (rst)
    op == cda_pkg::OP_DAY_R |=> rem_day < cda_pkg::SEC_PER_DAY)
    else $error("day remainder out of range");

  a_time_split: assert property (@(posedge clk) disable iff (rst)
    op == cda_pkg::OP_MIN_R |=> second <= cda_pkg::MINSEC_MAX &&
      minute <= cda_pkg::MINSEC_MAX && hour <= cda_pkg::HOUR_MAX)
    else $error("time of day out of range after split");

endmodule

// ----- rtl/core/cda_ctrl.sv -----
// ----------------------------------------------------------------------------
// cda_ctrl
// Sequencer: accepts one transaction, steps the datapath, hands off result.
// ----------------------------------------------------------------------------
module cda_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  input  cda_pkg::sts_t sts,
  output cda_pkg::op_t  op
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LEAP_Q,
    S_LEAP_F,
    S_CHECK,
    S_DIV,
    S_SUM,
    S_DAY_Q,
    S_DAY_R,
    S_HOUR_Q,
    S_HOUR_R,
    S_MIN_Q,
    S_MIN_R,
    S_STEP,
    S_FIN
  } state_t;

  state_t state;
  logic   stepping;   // leap pass re-entered from the day stepper
  logic   out_free;

  assign req_ready = state == S_IDLE;
  assign out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    op = cda_pkg::OP_NONE;
    unique case (state)
      S_IDLE:   op = req_valid ? cda_pkg::OP_LOAD : cda_pkg::OP_NONE;
      S_LEAP_Q: op = cda_pkg::OP_LEAP_Q;
      S_LEAP_F: op = cda_pkg::OP_LEAP_F;
      S_CHECK:  op = cda_pkg::OP_CHECK;
      S_DIV:    op = sts.ok ? cda_pkg::OP_DIV_MS : cda_pkg::OP_NONE;
      S_SUM:    op = cda_pkg::OP_SUM;
      S_DAY_Q:  op = cda_pkg::OP_DAY_Q;
      S_DAY_R:  op = cda_pkg::OP_DAY_R;
      S_HOUR_Q: op = cda_pkg::OP_HOUR_Q;
      S_HOUR_R: op = cda_pkg::OP_HOUR_R;
      S_MIN_Q:  op = cda_pkg::OP_MIN_Q;
      S_MIN_R:  op = cda_pkg::OP_MIN_R;
      S_STEP:   op = sts.days_zero ? cda_pkg::OP_NONE : cda_pkg::OP_STEP;
      S_FIN:    op = out_free ? cda_pkg::OP_EMIT : cda_pkg::OP_NONE;
      default:  op = cda_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      stepping  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_FIN && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state    <= S_LEAP_Q;
            stepping <= 1'b0;
          end
        end
        S_LEAP_Q: state <= S_LEAP_F;
        S_LEAP_F: state <= stepping ? S_STEP : S_CHECK;
        S_CHECK:  state <= S_DIV;
        S_DIV:    state <= sts.ok ? S_SUM : S_FIN;
        S_SUM:    state <= S_DAY_Q;
        S_DAY_Q:  state <= S_DAY_R;
        S_DAY_R:  state <= S_HOUR_Q;
        S_HOUR_Q: state <= S_HOUR_R;
        S_HOUR_R: state <= S_MIN_Q;
        S_MIN_Q:  state <= S_MIN_R;
        S_MIN_R: begin
          state    <= S_STEP;
          stepping <= 1'b1;
        end
        S_STEP: begin
          // new year: redo the leap test before stepping on
          if (sts.days_zero) begin
            state <= S_FIN;
          end else if (sts.year_roll) begin
            state <= S_LEAP_Q;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second transaction accepted while one is in progress");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    op == cda_pkg::OP_EMIT |-> !rsp_valid || rsp_ready)
    else $error("result register overwritten before hand-off");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    op == cda_pkg::OP_EMIT |=> rsp_valid && req_ready)
    else $error("result loaded without raising valid");

endmodule

// ----- rtl/core/calendar_datetime_advance_core.sv -----
// The time to a result grows with D, the number of whole days carried (0 to 50), and with
//   R, the year rollovers (0 or 1), each of which reruns the leap test; a date-time
//   that fails validation goes straight to the result. The day stepper sets the D term.
// Throughput: one transaction at a time; the next is taken the cycle after the result
//   is registered, while that result still waits at the output.
// Reset: synchronous, clears the sequencer and output valid; no clearing pass.
// ----------------------------------------------------------------------------
// calendar_datetime_advance_core
// Advances a Gregorian date-time by elapsed milliseconds between two timestamps.
// ----------------------------------------------------------------------------
module calendar_datetime_advance_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  cda_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output cda_pkg::rsp_t rsp
);

  cda_pkg::op_t  op;
  cda_pkg::sts_t sts;

  cda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .op        (op)
  );

  cda_datapath u_datapath (
    .clk (clk),
    .rst (rst),
    .op  (op),
    .req (req),
    .sts (sts),
    .rsp (rsp)
  );

endmodule

// ----- test/calendar_datetime_advance_core_tb.sv -----
// ----------------------------------------------------------------------------
// calendar_datetime_advance_core_tb
// Drives date-time transactions through the core under random idling on both
// sides and checks every result against a local calendar predictor: field
// validation, carry of elapsed seconds into the date, month, leap-year and
// year rollover, and the wrap of the millisecond difference.
// ----------------------------------------------------------------------------
module calendar_datetime_advance_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TAIL_CYCLES = 80;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DAYS_PER_MONTH [12] = '{31, 28, 31, 30, 31, 30,
                                                   31, 31, 30, 31, 30, 31};

  logic          clk;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_ready;
  cda_pkg::req_t req       = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  cda_pkg::rsp_t rsp;

  cda_pkg::rsp_t pending_datetimes [$];
  int unsigned   fail_count       = 0;
  int unsigned   req_gap_max      = 7;
  int unsigned   rsp_gap_max      = 7;
  int unsigned   rsp_hold_request = 0;

  calendar_datetime_advance_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL calendar_datetime_advance_core");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit is_leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
    if (m == 2) begin
      return is_leap_year(y) ? 29 : 28;
    end
    if (m < 1 || m > 12) begin
      return 31;
    end
    return DAYS_PER_MONTH[m - 1];
  endfunction

  function automatic cda_pkg::rsp_t advance_datetime(input cda_pkg::req_t r);
    int unsigned   yr, mon, dy, hr, mi, sec;
    int unsigned   elapsed_s, tot_s, tot_m, tot_h, day_cnt;
    logic [31:0]   diff_ms;
    bit            date_ok;
    cda_pkg::rsp_t res;
    yr  = 32'(r.start_year);
    mon = 32'(r.start_month);
    dy  = 32'(r.start_day);
    hr  = 32'(r.start_hour);
    mi  = 32'(r.start_minute);
    sec = 32'(r.start_second);
    date_ok = yr >= 1970 && mon >= 1 && mon <= 12 && dy >= 1 && hr <= 23 &&
              mi <= 59 && sec <= 59 && dy <= days_in_month(yr, mon);
    if (date_ok) begin
      diff_ms   = r.now_ms - r.received_ms;
      elapsed_s = diff_ms / 1000;
      tot_s     = sec + elapsed_s;
      tot_m     = mi + tot_s / 60;
      tot_h     = hr + tot_m / 60;
      day_cnt   = tot_h / 24;
      sec = tot_s % 60;
      mi  = tot_m % 60;
      hr  = tot_h % 24;
      while (day_cnt > 0) begin
        dy++;
        if (dy > days_in_month(yr, mon)) begin
          dy = 1;
          mon++;
          if (mon > 12) begin
            mon = 1;
            yr  = (yr + 1) & 32'h3FFF;
          end
        end
        day_cnt--;
      end
    end
    res.out_year   = yr[13:0];
    res.out_month  = mon[3:0];
    res.out_day    = dy[4:0];
    res.out_hour   = hr[4:0];
    res.out_minute = mi[5:0];
    res.out_second = sec[5:0];
    res.date_valid = date_ok;
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic cda_pkg::req_t make_datetime(input int unsigned y, input int unsigned mo,
                                                  input int unsigned d, input int unsigned h,
                                                  input int unsigned mi, input int unsigned s,
                                                  input logic [31:0] rx,
                                                  input logic [31:0] now);
    cda_pkg::req_t r;
    r.start_year   = y[13:0];
    r.start_month  = mo[3:0];
    r.start_day    = d[4:0];
    r.start_hour   = h[4:0];
    r.start_minute = mi[5:0];
    r.start_second = s[5:0];
    r.received_ms  = rx;
    r.now_ms       = now;
    return r;
  endfunction

  // well-formed date-time, biased towards month ends, midnight and leap cases
  function automatic cda_pkg::req_t random_valid_datetime();
    cda_pkg::req_t r;
    int unsigned   y, m, len;
    logic [31:0]   delta;
    case ($urandom_range(0, 7))
      0:       y = $urandom_range(1970, 16383);
      1:       y = 100 * $urandom_range(20, 99);
      2:       y = 4 * $urandom_range(493, 600);
      default: y = $urandom_range(1970, 2400);
    endcase
    if ($urandom_range(0, 3) == 0) begin
      m = $urandom_range(0, 1) ? 2 : 12;
    end else begin
      m = $urandom_range(1, 12);
    end
    len = days_in_month(y, m);
    r.start_year  = y[13:0];
    r.start_month = m[3:0];
    r.start_day   = ($urandom_range(0, 2) == 0) ? len[4:0] : 5'($urandom_range(1, len));
    if ($urandom_range(0, 2) == 0) begin
      r.start_hour   = 5'd23;
      r.start_minute = 6'd59;
    end else begin
      r.start_hour   = 5'($urandom_range(0, 23));
      r.start_minute = 6'($urandom_range(0, 59));
    end
    r.start_second = 6'($urandom_range(0, 59));
    case ($urandom_range(0, 3))
      0:       delta = $urandom_range(0, 1999);
      1:       delta = $urandom_range(0, 60_000);
      2:       delta = $urandom_range(0, 90_000_000);
      default: delta = $urandom;
    endcase
    r.received_ms = $urandom;
    r.now_ms      = r.received_ms + delta;
    return r;
  endfunction

  task automatic send_datetime(input cda_pkg::req_t r);
    int unsigned gap;
    gap = $urandom_range(0, req_gap_max);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    pending_datetimes.push_back(advance_datetime(r));
  endtask

  task automatic wait_for_results();
    req_valid <= 1'b0;
    while (pending_datetimes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- result checker

  initial begin
    int unsigned   gap;
    cda_pkg::rsp_t want;
    do @(posedge clk); while (rst);
    forever begin
      if (rsp_hold_request > 0) begin
        gap = rsp_hold_request;
        rsp_hold_request = 0;
      end else begin
        gap = $urandom_range(0, rsp_gap_max);
      end
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      if (pending_datetimes.size() == 0) begin
        $error("unexpected transaction on rsp: %p", rsp);
        fail_count++;
      end else begin
        want = pending_datetimes.pop_front();
        if (rsp.out_year !== want.out_year) begin
          $error("out_year: expected %0d, actual %0d", want.out_year, rsp.out_year);
          fail_count++;
        end
        if (rsp.out_month !== want.out_month) begin
          $error("out_month: expected %0d, actual %0d", want.out_month, rsp.out_month);
          fail_count++;
        end
        if (rsp.out_day !== want.out_day) begin
          $error("out_day: expected %0d, actual %0d", want.out_day, rsp.out_day);
          fail_count++;
        end
        if (rsp.out_hour !== want.out_hour) begin
          $error("out_hour: expected %0d, actual %0d", want.out_hour, rsp.out_hour);
          fail_count++;
        end
        if (rsp.out_minute !== want.out_minute) begin
          $error("out_minute: expected %0d, actual %0d", want.out_minute, rsp.out_minute);
          fail_count++;
        end
        if (rsp.out_second !== want.out_second) begin
          $error("out_second: expected %0d, actual %0d", want.out_second, rsp.out_second);
          fail_count++;
        end
        if (rsp.date_valid !== want.date_valid) begin
          $error("date_valid: expected %0d, actual %0d", want.date_valid, rsp.date_valid);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    send_datetime(make_datetime(1970, 1, 1, 0, 0, 0, 0, 0));
    send_datetime(make_datetime(1969, 12, 31, 23, 59, 59, 0, 1000));
    send_datetime(make_datetime(0, 0, 0, 0, 0, 0, 0, 0));
    send_datetime(make_datetime(16383, 15, 31, 31, 63, 63, 32'hFFFF_FFFF, 0));
    send_datetime(make_datetime(2023, 12, 31, 23, 59, 59, 5000, 6000));
    send_datetime(make_datetime(2024, 2, 28, 12, 0, 0, 0, 86_400_000));
    send_datetime(make_datetime(2023, 2, 28, 12, 0, 0, 0, 86_400_000));
    send_datetime(make_datetime(2100, 2, 28, 12, 0, 0, 0, 86_400_000));
    send_datetime(make_datetime(2000, 2, 29, 0, 0, 0, 0, 0));
    send_datetime(make_datetime(2023, 2, 29, 0, 0, 0, 0, 0));
    send_datetime(make_datetime(2100, 2, 29, 0, 0, 0, 0, 0));
    send_datetime(make_datetime(2024, 4, 31, 0, 0, 0, 0, 0));
    send_datetime(make_datetime(2024, 1, 0, 0, 0, 0, 0, 0));
    send_datetime(make_datetime(2024, 0, 10, 0, 0, 0, 0, 0));
    send_datetime(make_datetime(2024, 13, 10, 0, 0, 0, 0, 0));
    send_datetime(make_datetime(2024, 6, 15, 24, 0, 0, 0, 0));
    send_datetime(make_datetime(2024, 6, 15, 0, 60, 0, 0, 0));
    send_datetime(make_datetime(2024, 6, 15, 0, 0, 60, 0, 0));
    // largest elapsed time: now one below received
    send_datetime(make_datetime(2024, 12, 31, 23, 59, 59, 1, 0));
    send_datetime(make_datetime(2024, 3, 1, 0, 0, 0, 32'hFFFF_FC18, 0));
    send_datetime(make_datetime(2024, 3, 1, 0, 0, 0, 100, 1099));
    // year steps past the top of the field and wraps
    send_datetime(make_datetime(16383, 12, 31, 23, 59, 59, 0, 1000));
    send_datetime(make_datetime(9999, 12, 31, 23, 59, 59, 0, 32'hFFFF_FFFF));
    send_datetime(make_datetime(2024, 1, 31, 23, 59, 59, 0, 1000));
  endtask

  task automatic test_random_valid();
    for (int chunk = 0; chunk < 8; chunk++) begin
      req_gap_max = (chunk % 2 == 0) ? 7 : 0;
      rsp_gap_max = (chunk % 3 == 0) ? 0 : 7;
      repeat (100) send_datetime(random_valid_datetime());
    end
    req_gap_max = 7;
    rsp_gap_max = 7;
  endtask

  // raw bit patterns and well-formed date-times with one field pushed out of range
  task automatic test_random_invalid();
    cda_pkg::req_t r;
    logic [127:0]  raw;
    int unsigned   len;
    repeat (300) begin
      if ($urandom_range(0, 1) == 0) begin
        raw = {$urandom, $urandom, $urandom, $urandom};
        r   = raw[103:0];
      end else begin
        r   = random_valid_datetime();
        len = days_in_month(32'(r.start_year), 32'(r.start_month));
        case ($urandom_range(0, 5))
          0: r.start_year   = 14'($urandom_range(0, 1969));
          1: r.start_month  = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(13, 15));
          2: r.start_day    = (len < 31) ? 5'($urandom_range(len + 1, 31)) : 5'd0;
          3: r.start_hour   = 5'($urandom_range(24, 31));
          4: r.start_minute = 6'($urandom_range(60, 63));
          default: r.start_second = 6'($urandom_range(60, 63));
        endcase
      end
      send_datetime(r);
    end
  endtask

  // receiver stalls while the sender keeps offering back to back
  task automatic test_output_backpressure();
    req_gap_max = 0;
    rsp_hold_request = HOLD_CYCLES;
    repeat (30) send_datetime(random_valid_datetime());
    req_gap_max = 7;
  endtask

  task automatic test_sender_pause();
    wait_for_results();
    repeat (150) send_datetime(random_valid_datetime());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_valid();
    test_output_backpressure();
    test_random_invalid();
    test_sender_pause();
    wait_for_results();
    if (fail_count == 0) begin
      $display("PASS calendar_datetime_advance_core");
    end else begin
      $display("FAIL calendar_datetime_advance_core");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/cda_pkg.sv
rtl/core/cda_datapath.sv
rtl/core/cda_ctrl.sv
rtl/core/calendar_datetime_advance_core.sv
test/calendar_datetime_advance_core_tb.sv
